### design/edfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_pkg: shared types and constants of the EDF/LLF task scheduler
// Phase codes, controller states and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package edfs_pkg;

	typedef enum logic [1:0] {
		PH_BLOCKED = 2'd0,
		PH_READY   = 2'd1,
		PH_EXEC    = 2'd2,
		PH_FINISH  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_CREATED = 2'd0,
		ST_REJECT  = 2'd1,
		ST_TICK    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CREATE,
		S_ADVANCE,
		S_RUNDOWN,
		S_SCAN,
		S_COMMIT,
		S_OUT
	} state_t;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	typedef struct packed {
		logic load;      // capture input word
		logic create;    // write new slot
		logic advance;   // time step and release sweep
		logic rundown;   // count down running task
		logic scan_clr;  // reset scan pointer and best
		logic scan_step; // evaluate one slot
		logic commit;    // apply selection
		logic out_load;  // fill output register
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic scan_last;
	} dp_sts_t;

endpackage

### design/edfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_ctrl: scheduler sequencer
// Steps one word through create or tick phases, scanning one slot per cycle.
// ----------------------------------------------------------------------------
module edfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_busy,
	input  edfs_pkg::dp_sts_t sts,
	output edfs_pkg::dp_cmd_t cmd,
	output logic              idle
);
	import edfs_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:    if (in_fire) state_n = S_CREATE;
			S_CREATE:  state_n = sts.is_tick ? S_ADVANCE : S_OUT;
			S_ADVANCE: state_n = S_RUNDOWN;
			S_RUNDOWN: state_n = S_SCAN;
			S_SCAN:    if (sts.scan_last) state_n = S_COMMIT;
			S_COMMIT:  state_n = S_OUT;
			S_OUT:     if (!out_busy) state_n = S_IDLE;
			default:   state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		unique case (state_q)
			S_CREATE:  cmd.create = !sts.is_tick;
			S_ADVANCE: cmd.advance = 1'b1;
			S_RUNDOWN: begin
				cmd.rundown  = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			S_SCAN:    cmd.scan_step = 1'b1;
			S_COMMIT:  cmd.commit = 1'b1;
			S_OUT:     cmd.out_load = !out_busy;
			default:   ;
		endcase
	end

	assign idle = (state_q == S_IDLE);

endmodule

### design/edfs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_dp: scheduler datapath
// Slot table, time counter, running pointer and sequential best-key scan.
// ----------------------------------------------------------------------------
module edfs_dp #(
	parameter int MAX_TASKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  edfs_pkg::dp_cmd_t cmd,
	output edfs_pkg::dp_sts_t sts,
	input  logic              alg_q,
	input  logic              pre_q,
	input  logic              mode,
	input  logic [6:0]        release_time,
	input  logic [6:0]        deadline_time,
	input  logic [5:0]        execution_time,
	output logic [1:0]        status,
	output logic [2:0]        created_slot,
	output logic              running_valid,
	output logic [2:0]        running_slot,
	output logic              switched,
	output logic              finished_valid,
	output logic [2:0]        finished_slot,
	output logic [15:0]       current_time
);
	import edfs_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_TASKS);

	logic [6:0] rel_q [MAX_TASKS];
	logic [6:0] dl_q  [MAX_TASKS];
	logic [5:0] rem_q [MAX_TASKS];
	phase_t     ph_q  [MAX_TASKS];
	logic [CW-1:0] count_q;
	logic          run_v_q;
	logic [IW-1:0] run_q;
	logic [15:0]   time_q;

	logic          mode_q;
	logic [6:0]    in_rel_q, in_dl_q;
	logic [5:0]    in_ex_q;
	logic          reject_q, fin_v_q, sw_q;
	logic [IW-1:0] fin_q, created_q;

	logic [CW-1:0] scan_q;
	logic          have_q;
	logic [IW-1:0] best_q;
	logic signed [17:0] bkey_q;

	// scan evaluation of one slot
	logic [IW-1:0]      si;
	logic               cand;
	logic signed [17:0] key;
	assign si   = scan_q[IW-1:0];
	assign cand = (scan_q < count_q) && ((ph_q[si] == PH_READY) ||
		(run_v_q && run_q == si && ph_q[si] == PH_EXEC));
	assign key  = alg_q ? (18'($signed({1'b0, dl_q[si]})) - 18'($signed({1'b0, time_q}))
		- 18'($signed({1'b0, rem_q[si]}))) : 18'($signed({1'b0, dl_q[si]}));

	assign sts.is_tick   = mode_q;
	assign sts.scan_last = (scan_q == CMAX - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) ph_q[i] <= PH_BLOCKED;
			count_q <= '0;
			run_v_q <= 1'b0;
			run_q   <= '0;
			time_q  <= '0;
			status <= '0; created_slot <= '0; running_valid <= 1'b0;
			running_slot <= '0; switched <= 1'b0; finished_valid <= 1'b0;
			finished_slot <= '0; current_time <= '0;
		end else begin
			if (cmd.create && count_q < CMAX)
				ph_q[count_q[IW-1:0]] <= PH_BLOCKED;
			if (cmd.create && count_q < CMAX) count_q <= count_q + 1'b1;
			if (cmd.advance) begin
				if (time_q != TIME_MAX) time_q <= time_q + 16'd1;
				for (int i = 0; i < MAX_TASKS; i++)
					if (CW'(i) < count_q && ph_q[i] == PH_BLOCKED &&
					    {9'd0, rel_q[i]} <= ((time_q != TIME_MAX) ? time_q + 16'd1 : time_q))
						ph_q[i] <= PH_READY;
			end
			if (cmd.rundown && run_v_q && ph_q[run_q] == PH_EXEC &&
			    rem_q[run_q] <= 6'd1) begin
				ph_q[run_q] <= PH_FINISH;
				run_v_q     <= 1'b0;
			end
			if (cmd.commit && have_q && !(run_v_q && run_q == best_q) &&
			    !(!pre_q && run_v_q)) begin
				if (run_v_q) ph_q[run_q] <= PH_READY;
				ph_q[best_q] <= PH_EXEC;
				run_q   <= best_q;
				run_v_q <= 1'b1;
			end
			if (cmd.out_load) begin
				status <= mode_q ? ST_TICK : (reject_q ? ST_REJECT : ST_CREATED);
				created_slot   <= (!mode_q && !reject_q) ? 3'(created_q) : 3'd0;
				running_valid  <= run_v_q;
				running_slot   <= run_v_q ? 3'(run_q) : 3'd0;
				switched       <= mode_q & sw_q;
				finished_valid <= mode_q & fin_v_q;
				finished_slot  <= (mode_q & fin_v_q) ? 3'(fin_q) : 3'd0;
				current_time   <= time_q;
			end
		end
	end

	// payload, slot data and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			in_rel_q <= release_time;
			in_dl_q  <= deadline_time;
			in_ex_q  <= execution_time;
			fin_v_q  <= 1'b0;
			sw_q     <= 1'b0;
			fin_q    <= '0;
		end
		if (cmd.create) begin
			reject_q  <= (count_q >= CMAX);
			created_q <= count_q[IW-1:0];
			if (count_q < CMAX) begin
				rel_q[count_q[IW-1:0]] <= in_rel_q;
				dl_q[count_q[IW-1:0]]  <= (in_dl_q < in_rel_q) ? in_rel_q : in_dl_q;
				rem_q[count_q[IW-1:0]] <= in_ex_q;
			end
		end
		if (cmd.rundown && run_v_q && ph_q[run_q] == PH_EXEC) begin
			if (rem_q[run_q] <= 6'd1) begin
				rem_q[run_q] <= '0;
				fin_v_q <= 1'b1;
				fin_q   <= run_q;
			end else rem_q[run_q] <= rem_q[run_q] - 6'd1;
		end
		if (cmd.scan_clr) begin
			scan_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			bkey_q <= '0;
		end
		if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (cand && (!have_q || key < bkey_q)) begin
				have_q <= 1'b1;
				best_q <= si;
				bkey_q <= key;
			end
		end
		if (cmd.commit)
			sw_q <= have_q && !(run_v_q && run_q == best_q) && !(!pre_q && run_v_q);
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CMAX)
		else $error("task count beyond table");
	a_run_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && run_v_q) |-> ph_q[run_q] == PH_EXEC)
		else $error("running slot not executing");
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> time_q >= $past(time_q))
		else $error("time went backwards");

endmodule

### design/edf_llf_realtime_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_llf_realtime_task_scheduler: EDF / LLF real-time task scheduler
// Slot table of tasks; create words fill slots, tick words run the schedule.
// ----------------------------------------------------------------------------
// Sequence: a create word steps through the create and output states; a tick
//   word through create, advance, rundown, scan, commit and output states.
//   The scan visits one slot per cycle. One word is in flight at a time, and
//   a stalled result holds the next one.
// Reset: arst_n clears phases, task count, time, running pointer and config;
//   slot data has no reset and is only read after being written.
module edf_llf_realtime_task_scheduler #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [6:0]  release_time,
	input  logic [6:0]  deadline_time,
	input  logic [5:0]  execution_time,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  created_slot,
	output logic        running_valid,
	output logic [2:0]  running_slot,
	output logic        switched,
	output logic        finished_valid,
	output logic [2:0]  finished_slot,
	output logic [15:0] current_time
);
	import edfs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    idle, in_fire, alg_q, pre_q, out_v_q;

	// single-bit index: both register indexes map directly
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= 1'b0;
			pre_q <= 1'b0;
		end else if (cfg_valid) begin
			if (!cfg_index) alg_q <= cfg_data;
			else pre_q <= cfg_data;
		end
	end

	assign in_stall = !idle;
	assign in_fire  = in_valid && idle;

	// output word register: held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.out_load) out_v_q <= 1'b1;
		else if (!out_stall) out_v_q <= 1'b0;
	end
	assign out_valid = out_v_q;

	edfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_v_q && out_stall), .sts(sts), .cmd(cmd), .idle(idle)
	);

	edfs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.alg_q(alg_q), .pre_q(pre_q),
		.mode(mode), .release_time(release_time), .deadline_time(deadline_time),
		.execution_time(execution_time),
		.status(status), .created_slot(created_slot),
		.running_valid(running_valid), .running_slot(running_slot),
		.switched(switched), .finished_valid(finished_valid),
		.finished_slot(finished_slot), .current_time(current_time)
	);

endmodule
